// ===== rtl/sync_length_checksum_deframer_defines.svh =====
// Assertion macros shared by the deframer RTL.
// Expects a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef SYNC_LENGTH_CHECKSUM_DEFRAMER_DEFINES_SVH
`define SYNC_LENGTH_CHECKSUM_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS
`define SLCD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("slcd assertion failed");
`define SLCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slcd assertion failed");
`else
`define SLCD_ASSERT(lbl, prop)
`define SLCD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/slcd_pkg.sv =====
// Types and constants for the sync/length/checksum deframer.
// No dependencies; used by the top level.
`timescale 1ns / 1ps

package slcd_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'h58;
  localparam logic [7:0] SYNC_SECOND = 8'h59;

  // Only the first five payload bytes are ever read back.
  localparam int BUF_DEPTH = 5;
  localparam int BUF_IDX_W = 3;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PROPERTY_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLAG_MASK      = 2'd1;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  property_index;
    logic [31:0] property_value;
    logic        is_flag;
  } out_req_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [7:0]           data;
  } cfg_req_t;

endpackage

// ===== rtl/slcd_stream_if.sv =====
// Valid/ready channel carrying one request of a given payload type.
// Payload types come from slcd_pkg.
`timescale 1ns / 1ps

interface slcd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/sync_length_checksum_deframer.sv =====
// Frame parser for a serial byte stream of the form 'X' 'Y' LEN PAYLOAD SUM.
// One received byte is taken per cycle; each frame with a good checksum and a
// valid property index yields one property update on the result channel,
// registered into the output register, or into the skid entry if that is busy.
// A two-entry output register with skid keeps byte intake going while a
// result waits; input stalls only when both entries are full. Configuration
// writes are taken at once. Depends on slcd_pkg, slcd_stream_if and the
// assertion macro header.
`timescale 1ns / 1ps

`include "sync_length_checksum_deframer_defines.svh"

module sync_length_checksum_deframer
  import slcd_pkg::*;
#(
  parameter int MAX_PAYLOAD = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  slcd_stream_if.sink   in_chan,
  slcd_stream_if.source out_chan,
  slcd_stream_if.sink   cfg_chan
);

  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
  localparam logic [7:0]       MAX_LEN   = 8'(MAX_PAYLOAD);
  localparam logic [LEN_W-1:0] BUF_LIMIT = LEN_W'(BUF_DEPTH);

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_SYNC2   = 3'd1;
  localparam logic [2:0] PH_LEN     = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_SUM     = 3'd4;

  logic [3:0]       prop_count_r;
  logic [7:0]       flag_mask_r;

  logic [2:0]       phase_r, phase_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [LEN_W-1:0] wpos_r, wpos_nxt;
  logic [7:0]       buf_r [BUF_DEPTH];

  logic             out_valid_r, out_valid_nxt;
  out_req_t         out_data_r, out_data_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  out_req_t         skid_data_r, skid_data_nxt;

  logic       in_fire;
  logic       push;
  logic       pop;
  logic       res_valid;
  out_req_t   res;
  logic [7:0] b;
  logic       buf_we;

  assign b        = in_chan.data.rx_byte;
  assign in_chan.ready  = !skid_valid_r;
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  always_comb begin
    res.property_index = buf_r[0][2:0];
    res.is_flag        = flag_mask_r[buf_r[0][2:0]];
    if (res.is_flag) begin
      res.property_value = {31'd0, (buf_r[1] != 8'd0)};
    end else begin
      res.property_value = {buf_r[4], buf_r[3], buf_r[2], buf_r[1]};
    end
    res_valid = (sum_r == b) && (buf_r[0][7:3] == 5'd0) &&
                ({1'b0, buf_r[0][2:0]} < prop_count_r);
  end

  always_comb begin
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    sum_nxt   = sum_r;
    wpos_nxt  = wpos_r;
    buf_we    = 1'b0;
    push      = 1'b0;
    if (in_fire) begin
      unique case (phase_r)
        PH_SYNC2: begin
          phase_nxt = (b == SYNC_SECOND) ? PH_LEN : PH_HUNT;
        end
        PH_LEN: begin
          if (b == 8'd0 || b > MAX_LEN) begin
            phase_nxt = PH_HUNT;
          end else begin
            phase_nxt = PH_PAYLOAD;
            rem_nxt   = b[LEN_W-1:0];
            sum_nxt   = b;
            wpos_nxt  = '0;
          end
        end
        PH_PAYLOAD: begin
          buf_we   = (wpos_r < BUF_LIMIT);
          wpos_nxt = wpos_r + 1'b1;
          sum_nxt  = sum_r + b;
          if (rem_r != '0) begin
            rem_nxt = rem_r - 1'b1;
          end
          if (rem_nxt == '0) begin
            phase_nxt = PH_SUM;
          end
        end
        PH_SUM: begin
          push      = res_valid;
          phase_nxt = PH_HUNT;
        end
        default: begin
          phase_nxt = (b == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
        end
      endcase
    end
  end

  assign pop = out_valid_r && out_chan.ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || pop) begin
      out_valid_nxt = skid_valid_r || push;
      out_data_nxt  = skid_valid_r ? skid_data_r : res;
      if (skid_valid_r) begin
        skid_valid_nxt = push;
        skid_data_nxt  = res;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_count_r <= 4'd7;
      flag_mask_r  <= 8'd56;
      phase_r      <= PH_HUNT;
      rem_r        <= '0;
      sum_r        <= '0;
      wpos_r       <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
      for (int i = 0; i < BUF_DEPTH; i++) begin
        buf_r[i] <= 8'd0;
      end
    end else begin
      if (cfg_chan.valid) begin
        if (cfg_chan.data.index == REG_PROPERTY_COUNT) begin
          prop_count_r <= cfg_chan.data.data[3:0];
        end else if (cfg_chan.data.index == REG_FLAG_MASK) begin
          flag_mask_r <= cfg_chan.data.data;
        end
      end
      phase_r      <= phase_nxt;
      rem_r        <= rem_nxt;
      sum_r        <= sum_nxt;
      wpos_r       <= wpos_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      if (buf_we) begin
        buf_r[wpos_r[BUF_IDX_W-1:0]] <= b;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  `SLCD_ASSERT(a_skid_behind_out, !skid_valid_r || out_valid_r)
  `SLCD_ASSERT(a_push_only_on_sum, !push || (phase_r == PH_SUM))
  `SLCD_ASSERT(a_payload_count_sane,
               (phase_r != PH_PAYLOAD) || (rem_r != '0 && rem_r <= LEN_W'(MAX_PAYLOAD)))
  `SLCD_ASSERT_NEXT(a_sum_returns_to_hunt, in_fire && (phase_r == PH_SUM),
                    phase_r == PH_HUNT)

endmodule
